// File: hw/rtl/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// shared widths, request and status codes, register indexes and the issue
// record passed from the allocation stage to the address stage
// ----------------------------------------------------------------------------
package dsa_pkg;

    localparam int SLOT_W   = 10;
    localparam int ADDR_W   = 48;
    localparam int CAP_W    = 11;
    localparam int STRIDE_W = 12;
    localparam int CFG_W    = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_ADDR  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 2'd2;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              from_stack;
        logic              addr_en;
        logic [1:0]        status;
    } t_issue;

endpackage

// File: hw/rtl/dsa_alloc_ctl.sv
// ----------------------------------------------------------------------------
// dsa_alloc_ctl
// free stack memory, stack depth and bump counter; decides each request
// and registers the decision together with the popped slot
// ----------------------------------------------------------------------------
module dsa_alloc_ctl import dsa_pkg::*; #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_req_type,
    input  logic [SLOT_W-1:0] i_slot_index,
    input  logic [CAP_W-1:0]  i_capacity,
    output t_issue            o_issue,
    output logic [SLOT_W-1:0] o_pop_data
);

    localparam int FW = $clog2(MAX_SLOTS + 1);
    localparam int AW = $clog2(MAX_SLOTS);
    localparam int CW = (FW > CAP_W) ? FW : CAP_W;

    logic [SLOT_W-1:0] mem [MAX_SLOTS];

    logic [FW-1:0]     r_count;
    logic [FW-1:0]     n_count;
    logic [FW-1:0]     r_fresh;
    logic [FW-1:0]     n_fresh;
    t_issue            r_issue;
    t_issue            n_issue;
    logic [SLOT_W-1:0] r_pop_data;

    logic [CW-1:0]     cap_ext;
    logic [CW-1:0]     max_ext;
    logic [CW-1:0]     cap;
    logic [FW-1:0]     count_dec;
    logic              stack_empty;
    logic              stack_full;
    logic              fresh_ok;
    logic              do_push;
    logic              do_pop;

    always_comb begin
        cap_ext     = CW'(i_capacity);
        max_ext     = CW'(MAX_SLOTS);
        cap         = (cap_ext < max_ext) ? cap_ext : max_ext;
        count_dec   = r_count - FW'(1);
        stack_empty = (r_count == '0);
        stack_full  = (r_count == FW'(MAX_SLOTS));
        fresh_ok    = (CW'(r_fresh) < cap);

        n_count            = r_count;
        n_fresh            = r_fresh;
        do_push            = 1'b0;
        do_pop             = 1'b0;
        n_issue.slot       = i_slot_index;
        n_issue.from_stack = 1'b0;
        n_issue.addr_en    = 1'b0;
        n_issue.status     = ST_OK;

        case (i_req_type)
            REQ_ALLOC: begin
                if (!stack_empty) begin
                    do_pop             = 1'b1;
                    n_count            = count_dec;
                    n_issue.from_stack = 1'b1;
                    n_issue.addr_en    = 1'b1;
                end else if (fresh_ok) begin
                    n_fresh         = r_fresh + FW'(1);
                    n_issue.slot    = SLOT_W'(r_fresh);
                    n_issue.addr_en = 1'b1;
                end else begin
                    n_issue.slot   = '0;
                    n_issue.status = ST_NOSPACE;
                end
            end
            REQ_FREE: begin
                n_issue.addr_en = 1'b1;
                if (!stack_full) begin
                    do_push = 1'b1;
                    n_count = r_count + FW'(1);
                end else begin
                    n_issue.status = ST_OVERFLOW;
                end
            end
            REQ_ADDR: begin
                n_issue.addr_en = 1'b1;
            end
            default: begin
                n_issue.addr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fresh <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
            r_fresh <= n_fresh;
        end
    end

    // a push is written at its accept edge, before any later pop can read it
    always_ff @(posedge i_clk) begin
        if (i_accept && do_push) begin
            mem[r_count[AW-1:0]] <= i_slot_index;
        end
        if (i_accept && do_pop) begin
            r_pop_data <= mem[count_dec[AW-1:0]];
        end
        if (i_accept) begin
            r_issue <= n_issue;
        end
    end

    assign o_issue    = r_issue;
    assign o_pop_data = r_pop_data;

endmodule

// File: hw/rtl/dsa_addr_gen.sv
// ----------------------------------------------------------------------------
// dsa_addr_gen
// picks the granted slot, forms base plus slot times stride and holds the
// result word
// ----------------------------------------------------------------------------
module dsa_addr_gen import dsa_pkg::*; #(
    parameter int ADDRESS_BITS = 48
) (
    input  logic                i_clk,
    input  logic                i_load,
    input  t_issue              i_issue,
    input  logic [SLOT_W-1:0]   i_pop_data,
    input  logic [STRIDE_W-1:0] i_stride,
    input  logic [ADDR_W-1:0]   i_base,
    output logic [SLOT_W-1:0]   o_granted_slot,
    output logic [ADDR_W-1:0]   o_slot_address,
    output logic [1:0]          o_status
);

    localparam logic [ADDR_W-1:0] ADDR_MASK =
        (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}}
                                 : ((ADDR_W'(1) << ADDRESS_BITS) - ADDR_W'(1));

    logic [SLOT_W-1:0]          granted;
    logic [SLOT_W+STRIDE_W-1:0] prod;
    logic [ADDR_W-1:0]          sum;
    logic [ADDR_W-1:0]          n_addr;

    logic [SLOT_W-1:0]          r_granted;
    logic [ADDR_W-1:0]          r_addr;
    logic [1:0]                 r_status;

    always_comb begin
        granted = i_issue.from_stack ? i_pop_data : i_issue.slot;
        prod    = (SLOT_W + STRIDE_W)'(granted) * (SLOT_W + STRIDE_W)'(i_stride);
        sum     = i_base + ADDR_W'(prod);
        n_addr  = i_issue.addr_en ? (sum & ADDR_MASK) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_granted <= granted;
            r_addr    <= n_addr;
            r_status  <= i_issue.status;
        end
    end

    assign o_granted_slot = r_granted;
    assign o_slot_address = r_addr;
    assign o_status       = r_status;

endmodule

// File: hw/rtl/descriptor_slot_allocator.sv
// ----------------------------------------------------------------------------
// descriptor_slot_allocator
// stages: allocation registers the decision on accept, then address registers the result
// throughput: one request per cycle unless the output stalls; the free stack top is read from
//   a registered single-port memory in the accept cycle, address math follows
// reset: stack depth, bump counter and valid flags cleared, config registers at default
//   values, data registers and stack memory contents left as they are, no clearing pass
// ----------------------------------------------------------------------------
module descriptor_slot_allocator import dsa_pkg::*; #(
    parameter int MAX_SLOTS    = 1024,
    parameter int ADDRESS_BITS = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_req_type,
    input  logic [SLOT_W-1:0]    i_slot_index,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [SLOT_W-1:0]    o_granted_slot,
    output logic [ADDR_W-1:0]    o_slot_address,
    output logic [1:0]           o_status
);

    logic [CAP_W-1:0]    r_capacity;
    logic [STRIDE_W-1:0] r_stride;
    logic [ADDR_W-1:0]   r_base;
    logic                r_s1_valid;
    logic                r_out_valid;

    logic                out_free;
    logic                advance;
    logic                accept;
    t_issue              issue;
    logic [SLOT_W-1:0]   pop_data;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_W'(1024);
            r_stride   <= STRIDE_W'(32);
            r_base     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CAPACITY: r_capacity <= i_cfg_data[CAP_W-1:0];
                CFG_STRIDE:   r_stride   <= i_cfg_data[STRIDE_W-1:0];
                CFG_BASE:     r_base     <= i_cfg_data[ADDR_W-1:0];
                default:      r_base     <= r_base;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    dsa_alloc_ctl #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_alloc_ctl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_req_type   (i_req_type),
        .i_slot_index (i_slot_index),
        .i_capacity   (r_capacity),
        .o_issue      (issue),
        .o_pop_data   (pop_data)
    );

    dsa_addr_gen #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_addr_gen (
        .i_clk          (i_clk),
        .i_load         (advance),
        .i_issue        (issue),
        .i_pop_data     (pop_data),
        .i_stride       (r_stride),
        .i_base         (r_base),
        .o_granted_slot (o_granted_slot),
        .o_slot_address (o_slot_address),
        .o_status       (o_status)
    );

    assign o_out_valid = r_out_valid;

endmodule
